// ===== hdl/sle_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Scancode line editor package
// Shared types, codes and the set-1 US key table.
// ---------------------------------------------------------------------------
package sle_pkg;

  // Default line buffer depth and queue depths.
  localparam int DEFAULT_LINE_DEPTH = 256;
  localparam int OP_Q_DEPTH         = 2;
  localparam int OUT_Q_DEPTH        = 4;

  // Input command codes.
  localparam logic [1:0] CMD_SCAN  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Result kind codes.
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_KEY  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Scancodes with special handling.
  localparam logic [7:0] KEY_RELEASE   = 8'h80;
  localparam logic [7:0] KEY_BACKSPACE = 8'h0E;
  localparam logic [7:0] KEY_ENTER     = 8'h1C;

  // ASCII characters produced by the editing keys.
  localparam logic [7:0] ASCII_NUL = 8'h00;
  localparam logic [7:0] ASCII_BS  = 8'h08;
  localparam logic [7:0] ASCII_LF  = 8'h0A;
  localparam logic [7:0] ASCII_CR  = 8'h0D;

  // One input request.
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] scan_byte;
    logic [7:0] read_position;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_char;
    logic       ready_flag;
    logic [7:0] line_length;
    logic       last_of_run;
  } out_item_t;

  // Decoded operation handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_READ,
    OP_CLEAR,
    OP_ENTER,
    OP_BKSP,
    OP_KEY
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] ch;
    logic [7:0] pos;
  } op_t;

  // US layout make-code table; codes outside the table and holes give NUL.
  function automatic logic [7:0] us_map(input logic [7:0] code);
    logic [7:0] ch;
    case (code)
      8'h02: ch = 8'h31;
      8'h03: ch = 8'h32;
      8'h04: ch = 8'h33;
      8'h05: ch = 8'h34;
      8'h06: ch = 8'h35;
      8'h07: ch = 8'h36;
      8'h08: ch = 8'h37;
      8'h09: ch = 8'h38;
      8'h0A: ch = 8'h39;
      8'h0B: ch = 8'h30;
      8'h0C: ch = 8'h2D;
      8'h0D: ch = 8'h3D;
      8'h0E: ch = ASCII_BS;
      8'h0F: ch = 8'h09;
      8'h10: ch = 8'h71;
      8'h11: ch = 8'h77;
      8'h12: ch = 8'h65;
      8'h13: ch = 8'h72;
      8'h14: ch = 8'h74;
      8'h15: ch = 8'h79;
      8'h16: ch = 8'h75;
      8'h17: ch = 8'h69;
      8'h18: ch = 8'h6F;
      8'h19: ch = 8'h70;
      8'h1A: ch = 8'h5B;
      8'h1B: ch = 8'h5D;
      8'h1C: ch = ASCII_LF;
      8'h1E: ch = 8'h61;
      8'h1F: ch = 8'h73;
      8'h20: ch = 8'h64;
      8'h21: ch = 8'h66;
      8'h22: ch = 8'h67;
      8'h23: ch = 8'h68;
      8'h24: ch = 8'h6A;
      8'h25: ch = 8'h6B;
      8'h26: ch = 8'h6C;
      8'h27: ch = 8'h3B;
      8'h28: ch = 8'h27;
      8'h29: ch = 8'h60;
      8'h2B: ch = 8'h5C;
      8'h2C: ch = 8'h7A;
      8'h2D: ch = 8'h78;
      8'h2E: ch = 8'h63;
      8'h2F: ch = 8'h76;
      8'h30: ch = 8'h62;
      8'h31: ch = 8'h6E;
      8'h32: ch = 8'h6D;
      8'h33: ch = 8'h2C;
      8'h34: ch = 8'h2E;
      8'h35: ch = 8'h2F;
      8'h37: ch = 8'h2A;
      8'h39: ch = 8'h20;
      default: ch = ASCII_NUL;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sle_fifo.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Scancode line editor queue
// Small register-based FIFO; DEPTH must be a power of two.
// ---------------------------------------------------------------------------
module sle_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire T                           wdata,
  output logic                            full,
  input  wire logic                       pop,
  output T                                rdata,
  output logic                            empty,
  output logic [$clog2(DEPTH):0]          count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH) + 1;

  T                   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  // Handshake qualification.
  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];
  assign count   = count_r;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sle_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Scancode line editor front end
// Accepts requests, drops releases and unmapped codes, decodes the rest.
// ---------------------------------------------------------------------------
module sle_front
  import sle_pkg::*;
(
  input  wire logic     in_push,
  input  wire in_item_t in_data,
  output logic          in_full,
  output logic          op_push,
  output op_t           op_data,
  input  wire logic     op_full,
  input  wire logic     rst_n
);

  logic       keep;
  logic [7:0] key_ch;

  assign key_ch = us_map(in_data.scan_byte);

  // Classify the request into an operation for the back end.
  always_comb begin
    keep         = 1'b0;
    op_data.kind = OP_KEY;
    op_data.ch   = key_ch;
    op_data.pos  = in_data.read_position;
    case (in_data.cmd)
      CMD_READ: begin
        keep         = 1'b1;
        op_data.kind = OP_READ;
      end
      CMD_CLEAR: begin
        keep         = 1'b1;
        op_data.kind = OP_CLEAR;
      end
      CMD_SCAN: begin
        if ((in_data.scan_byte & KEY_RELEASE) == '0) begin
          if (in_data.scan_byte == KEY_ENTER) begin
            keep         = 1'b1;
            op_data.kind = OP_ENTER;
          end else if (in_data.scan_byte == KEY_BACKSPACE) begin
            keep         = 1'b1;
            op_data.kind = OP_BKSP;
          end else if (key_ch != ASCII_NUL) begin
            keep         = 1'b1;
            op_data.kind = OP_KEY;
          end
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Requests are taken whenever the operation queue has room.
  assign in_full = op_full || !rst_n;
  assign op_push = in_push && !in_full && keep;

endmodule
`default_nettype wire

// ===== hdl/sle_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Scancode line editor back end
// Executes decoded operations on the line buffer and forms results.
// ---------------------------------------------------------------------------
module sle_back
  import sle_pkg::*;
#(
  parameter int LINE_DEPTH  = DEFAULT_LINE_DEPTH,
  parameter int OUT_DEPTH   = OUT_Q_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       text_mode,
  input  wire logic                       op_empty,
  input  wire op_t                        op_data,
  output logic                            op_pop,
  input  wire logic [$clog2(OUT_DEPTH):0] out_count,
  output logic                            res_valid,
  output out_item_t                       res_data
);

  localparam int CNT_W = $clog2(LINE_DEPTH);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(LINE_DEPTH - 1);

  typedef enum logic {
    ST_FIRST,
    ST_SECOND
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             done_r, done_nxt;
  logic             res_valid_r, res_valid_nxt;
  out_item_t        res_r, res_nxt;
  logic             rd_sel_r, rd_sel_nxt;
  logic             hit_r, hit_nxt;
  logic [7:0]       store_r [LINE_DEPTH];
  logic [7:0]       rd_data_r;
  logic             can_go;
  logic             mem_we;
  logic [CNT_W-1:0] raddr;
  logic             emit;
  logic [1:0]       kind;
  logic [7:0]       ch;
  logic             last;

  // Execute only when the result queue is sure to have room.
  assign can_go = !op_empty &&
                  ((int'(out_count) + int'(res_valid_r)) < OUT_DEPTH);
  assign raddr  = CNT_W'(op_data.pos);

  // Operation execution.
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    done_nxt   = done_r;
    op_pop     = 1'b0;
    mem_we     = 1'b0;
    emit       = 1'b0;
    kind       = KIND_ECHO;
    ch         = op_data.ch;
    last       = 1'b1;
    rd_sel_nxt = 1'b0;
    hit_nxt    = CMP_W'(op_data.pos) < CMP_W'(fill_r);
    if (can_go) begin
      case (op_data.kind)
        OP_READ: begin
          op_pop     = 1'b1;
          emit       = 1'b1;
          kind       = KIND_READ;
          rd_sel_nxt = 1'b1;
        end
        OP_CLEAR: begin
          op_pop   = 1'b1;
          fill_nxt = '0;
          done_nxt = 1'b0;
        end
        OP_ENTER: begin
          emit = 1'b1;
          if (!text_mode) begin
            op_pop = 1'b1;
            kind   = KIND_KEY;
            ch     = ASCII_LF;
          end else if (state_r == ST_FIRST) begin
            // Carriage return first; the request stays queued for the line feed.
            done_nxt  = 1'b1;
            ch        = ASCII_CR;
            last      = 1'b0;
            state_nxt = ST_SECOND;
          end else begin
            op_pop    = 1'b1;
            ch        = ASCII_LF;
            state_nxt = ST_FIRST;
          end
        end
        OP_BKSP: begin
          op_pop = 1'b1;
          ch     = ASCII_BS;
          if (!text_mode) begin
            emit = 1'b1;
            kind = KIND_KEY;
          end else if (fill_r != '0) begin
            emit     = 1'b1;
            fill_nxt = fill_r - 1'b1;
          end
        end
        OP_KEY: begin
          op_pop = 1'b1;
          if (fill_r < LAST_IDX) begin
            emit = 1'b1;
            if (!text_mode) begin
              kind = KIND_KEY;
            end else begin
              mem_we   = 1'b1;
              fill_nxt = fill_r + 1'b1;
            end
          end
        end
        default: begin
          op_pop = 1'b1;
        end
      endcase
    end
    res_valid_nxt        = emit;
    res_nxt.out_kind     = kind;
    res_nxt.out_char     = ch;
    res_nxt.ready_flag   = done_nxt;
    res_nxt.line_length  = 8'(fill_nxt);
    res_nxt.last_of_run  = last;
  end

  // State and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FIRST;
      fill_r      <= '0;
      done_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      done_r      <= done_nxt;
      res_valid_r <= res_valid_nxt;
    end
    res_r    <= res_nxt;
    rd_sel_r <= rd_sel_nxt;
    hit_r    <= hit_nxt;
  end

  // Line buffer with registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[fill_r] <= op_data.ch;
    end
    rd_data_r <= store_r[raddr];
  end

  // Reads beyond the line length return NUL.
  always_comb begin
    res_data = res_r;
    if (rd_sel_r) begin
      res_data.out_char = hit_r ? rd_data_r : ASCII_NUL;
    end
  end
  assign res_valid = res_valid_r;

endmodule
`default_nettype wire

// ===== hdl/scancode_line_editor.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Scancode line editor
// PS/2 set-1 scancode decoder with a local line buffer and echo.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter through in_push/in_full as a queue write: a request is
//   taken on a clock edge with in_push high and in_full low. Results leave
//   through out_empty/out_pop as a queue read: the oldest result sits on
//   out_data while out_empty is low and is taken with out_pop.
//   cfg_we/cfg_wdata writes text_mode; write it only while the block is idle.
//   A request's first result shows after the operation queue, the back end
//   result register and the output queue. Requests are taken one per cycle
//   while in_full is low; Enter in text mode holds the back end for a CR echo
//   and then an LF echo. The back end runs one operation step per cycle while
//   the result queue has room. Releases, unmapped codes, dropped keys and line
//   resets give no result. Reset empties both queues, clears the line and sets
//   text_mode. The line buffer is not cleared; only written positions are ever
//   read back. When the receiver stalls, up to four results wait in the output
//   queue and two requests in the operation queue; after that in_full rises.
// ---------------------------------------------------------------------------
module scancode_line_editor
  import sle_pkg::*;
#(
  parameter int LINE_DEPTH = DEFAULT_LINE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_push,
  input  wire in_item_t  in_data,
  output logic           in_full,
  output logic           out_empty,
  input  wire logic      out_pop,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata
);

  logic                          text_mode_r;
  logic                          op_push, op_full, op_empty, op_pop;
  op_t                           op_in, op_out;
  logic [$clog2(OP_Q_DEPTH):0]   op_count;
  logic                          res_valid, out_full;
  out_item_t                     res_data;
  logic [$clog2(OUT_Q_DEPTH):0]  out_count;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_mode_r <= 1'b1;
    end else if (cfg_we) begin
      text_mode_r <= cfg_wdata;
    end
  end

  // Front end: request decode.
  sle_front u_front (
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .op_push (op_push),
    .op_data (op_in),
    .op_full (op_full),
    .rst_n   (rst_n)
  );

  // Operation queue between front and back end.
  sle_fifo #(
    .T     (op_t),
    .DEPTH (OP_Q_DEPTH)
  ) u_op_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (op_push),
    .wdata (op_in),
    .full  (op_full),
    .pop   (op_pop),
    .rdata (op_out),
    .empty (op_empty),
    .count (op_count)
  );

  // Back end: line buffer and result formation.
  sle_back #(
    .LINE_DEPTH (LINE_DEPTH),
    .OUT_DEPTH  (OUT_Q_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .text_mode (text_mode_r),
    .op_empty  (op_empty),
    .op_data   (op_out),
    .op_pop    (op_pop),
    .out_count (out_count),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  // Result queue.
  sle_fifo #(
    .T     (out_item_t),
    .DEPTH (OUT_Q_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .wdata (res_data),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty),
    .count (out_count)
  );

`ifndef SYNTHESIS
  // The back end never produces a result the output queue cannot hold.
  a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_valid && out_full))
    else $error("result produced while output queue full");

  // The only non-final result is the carriage return echo of Enter.
  a_non_last_is_cr: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.last_of_run) |->
      (out_data.out_kind == KIND_ECHO && out_data.out_char == ASCII_CR))
    else $error("unexpected non-final result");

  // Read data always closes its run.
  a_read_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.out_kind == KIND_READ) |-> out_data.last_of_run)
    else $error("read result not marked final");

  // The operation queue count never exceeds its depth.
  a_op_count: assert property (@(posedge clk) disable iff (!rst_n)
    int'(op_count) <= OP_Q_DEPTH)
    else $error("operation queue count out of range");
`endif

endmodule
`default_nettype wire
